// File: rtl/acbu_pkg.sv
// Package for the ALU / condition / branch execute unit.
// Holds opcode codes, sequencer states and the default data width.
package acbu_pkg;

    localparam int DataWidthDefault = 32;

    typedef enum logic [4:0] {
        OP_MOV  = 5'd0,  OP_ADD  = 5'd1,  OP_SUB  = 5'd2,  OP_MUL  = 5'd3,
        OP_DIV  = 5'd4,  OP_MOD  = 5'd5,  OP_CMP  = 5'd6,  OP_SWAP = 5'd7,
        OP_AND  = 5'd8,  OP_OR   = 5'd9,  OP_NOT  = 5'd10, OP_XOR  = 5'd11,
        OP_SHL  = 5'd12, OP_SHR  = 5'd13, OP_JMP  = 5'd14, OP_JE   = 5'd15,
        OP_JG   = 5'd16, OP_JL   = 5'd17, OP_JZ   = 5'd18, OP_JN   = 5'd19,
        OP_JP   = 5'd20, OP_JNZ  = 5'd21, OP_JNN  = 5'd22, OP_JNP  = 5'd23,
        OP_STOP = 5'd24
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_DONE
    } t_state;

endpackage

// File: rtl/alu_condition_branch_unit.sv
// Execute unit top level: sequencer, shared add/subtract unit and result register.
// Depends on acbu_pkg for opcodes and states.
//
// One instruction at a time. A word is taken on s_axis, then the block works
// on it in ST_ITER and ST_DONE through one shared adder/subtractor before the
// result word is valid: multiply runs as shift-and-add, divide and modulo as
// restoring division one quotient bit per cycle, shifts one bit position per
// cycle, and every other operation takes one pass. The result is held in an
// output register until m_axis takes it; s_axis_tready stays low meanwhile,
// so the next word is taken at the earliest in the cycle after the result
// word leaves. The zero/negative condition code is kept across instructions.
module alu_condition_branch_unit #(
    parameter int DATA_WIDTH = acbu_pkg::DataWidthDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata fields from bit 0: operation[4:0], operand_a, operand_b, ax_value
    input  logic [((5+3*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // tdata fields from bit 0: write_a_enable, write_a_value, write_b_enable,
    // write_b_value, branch_taken, branch_target, halt, divide_by_zero,
    // zero_flag, negative_flag
    output logic [((7+3*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    localparam int W   = DATA_WIDTH;
    localparam int CW  = $clog2(W + 1);
    localparam int OW  = ((7 + 3*W + 7) / 8) * 8;

    acbu_pkg::t_state r_state, n_state;
    logic [4:0]   r_op, n_op;
    logic [W-1:0] r_a, n_a, r_b, n_b, r_ax, n_ax;
    logic [W-1:0] r_acc, n_acc;       // partial product / remainder / shift value
    logic [W-1:0] r_q, n_q;           // multiplier bits / quotient / shift count
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_z, n_z, r_n, n_n;
    logic r_ov, n_ov;
    logic [OW-1:0] r_out, n_out;

    // shared adder / subtractor
    logic [W:0]   u_x, u_y, u_sum;
    logic         u_sub;
    assign u_sum = u_sub ? (u_x - u_y) : (u_x + u_y);

    logic [W-1:0] ma, mb, res;
    logic         a_neg, b_neg, bzero, lt_ab, lt_axa, lt_aax;
    logic         wa_en, wb_en, br, halt, dz, set_cc;
    logic [W-1:0] wa, wb, tgt;
    logic [W-1:0] rem_sh;

    assign s_axis_tready = (r_state == acbu_pkg::ST_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    assign a_neg = r_a[W-1];
    assign b_neg = r_b[W-1];
    assign ma    = a_neg ? (~r_a + 1'b1) : r_a;
    assign mb    = b_neg ? (~r_b + 1'b1) : r_b;
    assign bzero = (r_b == '0);
    assign lt_ab  = $signed(r_a) < $signed(r_b);
    assign lt_axa = $signed(r_ax) < $signed(r_a);
    assign lt_aax = $signed(r_a) < $signed(r_ax);
    assign rem_sh = {r_acc[W-2:0], r_q[W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acbu_pkg::ST_IDLE;
            r_z     <= 1'b0;
            r_n     <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_z     <= n_z;
            r_n     <= n_n;
            r_ov    <= n_ov;
        end
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_ax  <= n_ax;
        r_acc <= n_acc;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op; n_a = r_a; n_b = r_b; n_ax = r_ax;
        n_acc = r_acc; n_q = r_q; n_cnt = r_cnt;
        n_z = r_z; n_n = r_n; n_out = r_out;
        n_ov = r_ov && !m_axis_tready;
        u_x = '0; u_y = '0; u_sub = 1'b0;
        wa_en = 1'b0; wb_en = 1'b0; br = 1'b0; halt = 1'b0; dz = 1'b0;
        set_cc = 1'b0; wa = '0; wb = '0; tgt = '0; res = '0;

        case (r_state)
            acbu_pkg::ST_IDLE: begin
                // capture the word and load the iteration registers
                if (s_axis_tvalid && s_axis_tready) begin
                    n_op  = s_axis_tdata[4:0];
                    n_a   = s_axis_tdata[5 +: W];
                    n_b   = s_axis_tdata[5+W +: W];
                    n_ax  = s_axis_tdata[5+2*W +: W];
                    n_cnt = '0;
                    n_state = acbu_pkg::ST_ITER;
                end
            end
            acbu_pkg::ST_ITER: begin
                case (r_op)
                    acbu_pkg::OP_MUL: begin
                        // shift-and-add from the top multiplier bit down
                        if (r_cnt == '0) begin
                            n_acc = '0;
                            n_q   = r_b;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            u_x = {1'b0, r_acc[W-2:0], 1'b0};
                            u_y = r_q[W-1] ? {1'b0, r_a} : '0;
                            n_acc = u_sum[W-1:0];
                            n_q   = {r_q[W-2:0], 1'b0};
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == CW'(W)) n_state = acbu_pkg::ST_DONE;
                        end
                    end
                    acbu_pkg::OP_DIV, acbu_pkg::OP_MOD: begin
                        // restoring division on magnitudes, one bit a cycle
                        if (r_cnt == '0) begin
                            n_acc = '0;
                            n_q   = ma;
                            n_cnt = r_cnt + 1'b1;
                            if (bzero) n_state = acbu_pkg::ST_DONE;
                        end else begin
                            u_x = {r_acc[W-1], rem_sh};
                            u_y = {1'b0, mb};
                            u_sub = 1'b1;
                            n_q = {r_q[W-2:0], !u_sum[W]};
                            n_acc = u_sum[W] ? rem_sh : u_sum[W-1:0];
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == CW'(W)) n_state = acbu_pkg::ST_DONE;
                        end
                    end
                    acbu_pkg::OP_SHL, acbu_pkg::OP_SHR: begin
                        // one bit position per cycle, saturating count
                        if (r_cnt == '0) begin
                            n_acc = r_a;
                            n_q   = r_b;
                            n_cnt = r_cnt + 1'b1;
                        end else begin
                            if (r_q != '0) begin
                                n_acc = (r_op == acbu_pkg::OP_SHL) ?
                                        {r_acc[W-2:0], 1'b0} :
                                        {r_acc[W-1], r_acc[W-1:1]};
                                n_q = r_q - 1'b1;
                            end
                            n_cnt = r_cnt + 1'b1;
                            if (r_cnt == CW'(W) || r_q == '0)
                                n_state = acbu_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_state = acbu_pkg::ST_DONE;
                    end
                endcase
            end
            acbu_pkg::ST_DONE: begin
                // form the result word (shared unit for add/sub/div/mod) and latch it
                if (!r_ov) begin
                    case (r_op)
                        acbu_pkg::OP_MOV: begin res = r_b; set_cc = 1'b1; end
                        acbu_pkg::OP_ADD: begin
                            u_x = {1'b0, r_a}; u_y = {1'b0, r_b};
                            res = u_sum[W-1:0]; set_cc = 1'b1;
                        end
                        acbu_pkg::OP_SUB: begin
                            u_x = {1'b0, r_a}; u_y = {1'b0, r_b}; u_sub = 1'b1;
                            res = u_sum[W-1:0]; set_cc = 1'b1;
                        end
                        acbu_pkg::OP_MUL: begin res = r_acc; set_cc = 1'b1; end
                        acbu_pkg::OP_DIV: begin
                            if (bzero) dz = 1'b1;
                            else begin
                                u_x = '0; u_y = {1'b0, r_q};
                                u_sub = a_neg ^ b_neg;
                                res = u_sum[W-1:0]; set_cc = 1'b1;
                            end
                        end
                        acbu_pkg::OP_MOD: begin
                            if (bzero) dz = 1'b1;
                            else begin
                                u_x = '0; u_y = {1'b0, r_acc};
                                u_sub = a_neg;
                                res = u_sum[W-1:0]; set_cc = 1'b1;
                            end
                        end
                        acbu_pkg::OP_CMP: begin
                            n_z = (r_a == r_b);
                            n_n = lt_ab;
                        end
                        acbu_pkg::OP_SWAP: begin
                            wa_en = 1'b1; wa = r_b; wb_en = 1'b1; wb = r_a;
                        end
                        acbu_pkg::OP_AND: begin res = r_a & r_b; set_cc = 1'b1; end
                        acbu_pkg::OP_OR:  begin res = r_a | r_b; set_cc = 1'b1; end
                        acbu_pkg::OP_NOT: begin res = ~r_a; set_cc = 1'b1; end
                        acbu_pkg::OP_XOR: begin res = r_a ^ r_b; set_cc = 1'b1; end
                        acbu_pkg::OP_SHL: begin
                            wa_en = 1'b1;
                            wa = (r_q != '0) ? '0 : r_acc;
                        end
                        acbu_pkg::OP_SHR: begin
                            wa_en = 1'b1;
                            wa = (r_q != '0) ? {W{r_acc[W-1]}} : r_acc;
                            wa[W-1] = 1'b0;
                        end
                        acbu_pkg::OP_JMP: begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_JE:  if (r_a == r_ax) begin br = 1'b1; tgt = r_b; end
                        acbu_pkg::OP_JG:  if (lt_axa) begin br = 1'b1; tgt = r_b; end
                        acbu_pkg::OP_JL:  if (lt_aax) begin br = 1'b1; tgt = r_b; end
                        acbu_pkg::OP_JZ:  if (r_z) begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_JN:  if (r_n) begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_JP:  if (!r_z && !r_n) begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_JNZ: if (!r_z) begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_JNN: if (!r_n) begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_JNP: if (r_z || r_n) begin br = 1'b1; tgt = r_a; end
                        acbu_pkg::OP_STOP: halt = 1'b1;
                        default: ;
                    endcase
                    if (set_cc) begin
                        wa_en = 1'b1;
                        wa = res;
                        n_z = (res == '0);
                        n_n = res[W-1];
                    end
                    n_out = '0;
                    n_out[0]             = wa_en;
                    n_out[1 +: W]        = wa;
                    n_out[1+W]           = wb_en;
                    n_out[2+W +: W]      = wb;
                    n_out[2+2*W]         = br;
                    n_out[3+2*W +: W]    = tgt;
                    n_out[3+3*W]         = halt;
                    n_out[4+3*W]         = dz;
                    n_out[5+3*W]         = n_z;
                    n_out[6+3*W]         = n_n;
                    n_ov = 1'b1;
                    n_state = acbu_pkg::ST_IDLE;
                end
            end
            default: n_state = acbu_pkg::ST_IDLE;
        endcase
    end

endmodule

// File: test/alu_condition_branch_unit_tb.sv
// Testbench for the ALU / condition / branch execute unit.
// Drives instruction words on s_axis, predicts each result word and checks m_axis.
// Depends on acbu_pkg and alu_condition_branch_unit.
`timescale 1ns / 100ps

module alu_condition_branch_unit_tb;

    localparam int DW = 32;
    localparam int IN_W = ((5 + 3 * DW + 7) / 8) * 8;
    localparam int OUT_W = ((7 + 3 * DW + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic          neg_flag;
        logic          zero_flag;
        logic          div_zero;
        logic          halt;
        logic [DW-1:0] br_target;
        logic          br_taken;
        logic [DW-1:0] wb_value;
        logic          wb_en;
        logic [DW-1:0] wa_value;
        logic          wa_en;
    } t_exec_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    // fields from bit 0: operation[4:0], operand_a, operand_b, ax_value
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    // fields from bit 0: write_a_enable, write_a_value, write_b_enable, write_b_value,
    // branch_taken, branch_target, halt, divide_by_zero, zero_flag, negative_flag
    logic [OUT_W-1:0] m_axis_tdata;

    t_exec_result expected_results[$];
    logic         cc_zero, cc_neg;
    int           error_count = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           cycle_count = 0;
    bit           stimulus_done = 0;

    alu_condition_branch_unit #(.DATA_WIDTH(DW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Short gaps mostly, now and then a long one
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Compute the result word of one instruction and advance the condition code
    function automatic t_exec_result execute_instr(acbu_pkg::t_op op, logic [DW-1:0] a,
                                                   logic [DW-1:0] b, logic [DW-1:0] ax);
        t_exec_result res;
        logic [DW-1:0] r, ma, mb;
        logic          sets_code;
        res = '0;
        r = '0;
        sets_code = 1'b0;
        case (op)
            acbu_pkg::OP_MOV: begin r = b; sets_code = 1'b1; end
            acbu_pkg::OP_ADD: begin r = a + b; sets_code = 1'b1; end
            acbu_pkg::OP_SUB: begin r = a - b; sets_code = 1'b1; end
            acbu_pkg::OP_MUL: begin r = a * b; sets_code = 1'b1; end
            acbu_pkg::OP_DIV, acbu_pkg::OP_MOD: begin
                if (b == 0) begin
                    res.div_zero = 1'b1;
                end else begin
                    ma = a[DW-1] ? -a : a;
                    mb = b[DW-1] ? -b : b;
                    if (op == acbu_pkg::OP_DIV) begin
                        r = ma / mb;
                        if (a[DW-1] ^ b[DW-1]) r = -r;
                    end else begin
                        r = ma % mb;
                        if (a[DW-1]) r = -r;
                    end
                    sets_code = 1'b1;
                end
            end
            acbu_pkg::OP_CMP: begin
                cc_zero = (a == b);
                cc_neg = ($signed(a) < $signed(b));
            end
            acbu_pkg::OP_SWAP: begin
                res.wa_en = 1'b1; res.wa_value = b;
                res.wb_en = 1'b1; res.wb_value = a;
            end
            acbu_pkg::OP_AND: begin r = a & b; sets_code = 1'b1; end
            acbu_pkg::OP_OR:  begin r = a | b; sets_code = 1'b1; end
            acbu_pkg::OP_NOT: begin r = ~a; sets_code = 1'b1; end
            acbu_pkg::OP_XOR: begin r = a ^ b; sets_code = 1'b1; end
            acbu_pkg::OP_SHL: begin
                res.wa_en = 1'b1;
                res.wa_value = (b >= DW) ? '0 : (a << b);
            end
            acbu_pkg::OP_SHR: begin
                res.wa_en = 1'b1;
                if (b >= DW) res.wa_value = {DW{a[DW-1]}};
                else res.wa_value = $signed(a) >>> b;
                res.wa_value[DW-1] = 1'b0;
            end
            acbu_pkg::OP_JMP: begin res.br_taken = 1'b1; res.br_target = a; end
            acbu_pkg::OP_JE: if (a == ax) begin
                res.br_taken = 1'b1; res.br_target = b;
            end
            acbu_pkg::OP_JG: if ($signed(ax) < $signed(a)) begin
                res.br_taken = 1'b1; res.br_target = b;
            end
            acbu_pkg::OP_JL: if ($signed(a) < $signed(ax)) begin
                res.br_taken = 1'b1; res.br_target = b;
            end
            acbu_pkg::OP_JZ: if (cc_zero) begin
                res.br_taken = 1'b1; res.br_target = a;
            end
            acbu_pkg::OP_JN: if (cc_neg) begin
                res.br_taken = 1'b1; res.br_target = a;
            end
            acbu_pkg::OP_JP: if (!cc_zero && !cc_neg) begin
                res.br_taken = 1'b1; res.br_target = a;
            end
            acbu_pkg::OP_JNZ: if (!cc_zero) begin
                res.br_taken = 1'b1; res.br_target = a;
            end
            acbu_pkg::OP_JNN: if (!cc_neg) begin
                res.br_taken = 1'b1; res.br_target = a;
            end
            acbu_pkg::OP_JNP: if (cc_zero || cc_neg) begin
                res.br_taken = 1'b1; res.br_target = a;
            end
            acbu_pkg::OP_STOP: res.halt = 1'b1;
            default: ;
        endcase
        if (sets_code) begin
            res.wa_en = 1'b1;
            res.wa_value = r;
            cc_zero = (r == 0);
            cc_neg = (r != 0) && r[DW-1];
        end
        res.zero_flag = cc_zero;
        res.neg_flag = cc_neg;
        return res;
    endfunction

    // Send one instruction word after a random gap; predict its result on acceptance
    task automatic send_instr(logic [4:0] op, logic [DW-1:0] a, logic [DW-1:0] b,
                              logic [DW-1:0] ax);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= IN_W'({ax, b, a, op});
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(execute_instr(acbu_pkg::t_op'(op), a, b, ax));
        words_sent++;
        @(negedge i_clk);
    endtask

    // Operand with bias toward edge values
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        logic [DW-1:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7FFF_FFFF;
        send_instr(acbu_pkg::OP_JZ, 5, 0, 0);               // code clear after reset
        send_instr(acbu_pkg::OP_ADD, mx, 1, 0);             // wraps negative
        send_instr(acbu_pkg::OP_SUB, mn, 1, 0);
        send_instr(acbu_pkg::OP_MUL, mx, mx, 0);
        send_instr(acbu_pkg::OP_DIV, mn, 32'hFFFF_FFFF, 0); // most negative over -1
        send_instr(acbu_pkg::OP_MOD, mn, 32'hFFFF_FFFF, 0);
        send_instr(acbu_pkg::OP_DIV, -7, 2, 0);             // truncate toward zero
        send_instr(acbu_pkg::OP_MOD, -7, 2, 0);             // remainder follows dividend
        send_instr(acbu_pkg::OP_MOD, 7, -2, 0);
        send_instr(acbu_pkg::OP_DIV, 9, 0, 0);              // zero divisor keeps code
        send_instr(acbu_pkg::OP_MOD, mn, 0, 0);
        send_instr(acbu_pkg::OP_CMP, mn, mx, 0);
        send_instr(acbu_pkg::OP_CMP, 3, 3, 0);
        send_instr(acbu_pkg::OP_SWAP, mn, mx, 0);
        send_instr(acbu_pkg::OP_NOT, '1, 0, 0);
        send_instr(acbu_pkg::OP_SHL, '1, 32, 0);            // shift count too large
        send_instr(acbu_pkg::OP_SHR, mn, 32'hFFFF_FFFF, 0); // negative count
        send_instr(acbu_pkg::OP_SHR, mn, 4, 0);
        send_instr(acbu_pkg::OP_SHL, 1, 31, 0);
        send_instr(acbu_pkg::OP_JE, 10, mx, 10);
        send_instr(acbu_pkg::OP_JG, mx, mn, mn);
        send_instr(acbu_pkg::OP_JL, mn, 7, mx);
        send_instr(acbu_pkg::OP_STOP, 0, 0, 0);
        send_instr(5'd25, '1, '1, '1);                      // unused opcode
        send_instr(5'd31, mn, mn, mn);
    endtask

    task automatic test_all_ops();
        for (int op = 0; op < 32; op++)
            send_instr(op[4:0], pick_operand(), pick_operand(), pick_operand());
    endtask

    // Random mix of flag branches, compare branches, divides, shifts, ALU ops and any opcode
    task automatic test_random(int count);
        logic [DW-1:0] a, b, ax;
        logic [4:0]    op;
        for (int n = 0; n < count; n++) begin
            a = pick_operand();
            b = pick_operand();
            ax = ($urandom_range(0, 3) == 0) ? a : pick_operand();
            case ($urandom_range(0, 5))
                0: op = 5'($urandom_range(acbu_pkg::OP_JZ, acbu_pkg::OP_JNP));
                1: op = 5'($urandom_range(acbu_pkg::OP_JMP, acbu_pkg::OP_JL));
                2: op = 5'($urandom_range(acbu_pkg::OP_DIV, acbu_pkg::OP_MOD));
                3: op = 5'($urandom_range(acbu_pkg::OP_SHL, acbu_pkg::OP_SHR));
                4: op = 5'($urandom_range(0, 31));
                default: op = 5'($urandom_range(acbu_pkg::OP_MOV, acbu_pkg::OP_XOR));
            endcase
            if (op inside {acbu_pkg::OP_SHL, acbu_pkg::OP_SHR} && $urandom_range(0, 1))
                b = $urandom_range(0, 33);
            send_instr(op, a, b, ax);
        end
    endtask

    // Drop m_axis_tready at random, in bursts
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
            m_axis_tready <= 1'b0;
            repeat (gap_length()) @(negedge i_clk);
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        t_exec_result got, exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_exec_result'(m_axis_tdata[$bits(t_exec_result)-1:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                words_checked++;
                if (got.wa_en !== exp_res.wa_en) begin
                    $error("write_a_enable exp %0d got %0d", exp_res.wa_en, got.wa_en);
                    error_count++;
                end
                if (got.wa_value !== exp_res.wa_value) begin
                    $error("write_a_value exp %h got %h", exp_res.wa_value, got.wa_value);
                    error_count++;
                end
                if (got.wb_en !== exp_res.wb_en) begin
                    $error("write_b_enable exp %0d got %0d", exp_res.wb_en, got.wb_en);
                    error_count++;
                end
                if (got.wb_value !== exp_res.wb_value) begin
                    $error("write_b_value exp %h got %h", exp_res.wb_value, got.wb_value);
                    error_count++;
                end
                if (got.br_taken !== exp_res.br_taken) begin
                    $error("branch_taken exp %0d got %0d", exp_res.br_taken, got.br_taken);
                    error_count++;
                end
                if (got.br_target !== exp_res.br_target) begin
                    $error("branch_target exp %h got %h", exp_res.br_target,
                           got.br_target);
                    error_count++;
                end
                if (got.halt !== exp_res.halt) begin
                    $error("halt exp %0d got %0d", exp_res.halt, got.halt);
                    error_count++;
                end
                if (got.div_zero !== exp_res.div_zero) begin
                    $error("divide_by_zero exp %0d got %0d", exp_res.div_zero,
                           got.div_zero);
                    error_count++;
                end
                if (got.zero_flag !== exp_res.zero_flag) begin
                    $error("zero_flag exp %0d got %0d", exp_res.zero_flag, got.zero_flag);
                    error_count++;
                end
                if (got.neg_flag !== exp_res.neg_flag) begin
                    $error("negative_flag exp %0d got %0d", exp_res.neg_flag, got.neg_flag);
                    error_count++;
                end
            end
        end
    end

    // Abort on a hang
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int drain;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cc_zero = 1'b0;
        cc_neg = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_all_ops();
        test_random(1300);
        s_axis_tvalid <= 1'b0;

        // Drain, then a margin of the block's latency
        drain = 0;
        while (expected_results.size() != 0 && drain < 100000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (2 * DW + 8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            error_count++;
        end
        $display("sent %0d instruction words, checked %0d results", words_sent, words_checked);
        $display("covered all opcodes, divide and shift edge cases, flag-driven branches");
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
rtl/acbu_pkg.sv
rtl/alu_condition_branch_unit.sv
test/alu_condition_branch_unit_tb.sv
